// ===== src/epoch_seconds_to_calendar_defines.svh =====
// Assertion macros shared by the checker of epoch_seconds_to_calendar.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("esc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ESC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("esc assertion failed");

`endif

// ===== src/esc_pkg.sv =====
// Shared types, constants and the month length table for the seconds-to-date block.
// No dependencies.
package esc_pkg;

  localparam int DAY_WIDTH    = 16;  // day number, fits 2^32 / 86400
  localparam int TOD_WIDTH    = 17;  // seconds of the day
  localparam int MINSEC_WIDTH = 12;  // seconds of the hour
  localparam int YEAR_WIDTH   = 12;

  localparam logic [TOD_WIDTH-1:0]    SECS_PER_DAY  = 17'd86400;
  localparam logic [MINSEC_WIDTH-1:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]              SECS_PER_MIN  = 6'd60;
  localparam logic [YEAR_WIDTH-1:0]   EPOCH_YEAR    = 12'd1970;
  localparam logic [8:0]              DAYS_COMMON   = 9'd365;
  localparam logic [8:0]              DAYS_LEAP     = 9'd366;
  localparam logic [3:0]              MONTH_JAN     = 4'd1;
  localparam logic [3:0]              MONTH_DEC     = 4'd12;

  // x / (2^s * d) == ((x >> s) * RECIP) >> SHIFT, RECIP = ceil(2^SHIFT / d),
  // exact over the full range of each dividend
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // d = 675, s = 7
  localparam int          DAY_SHIFT  = 35;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;      // d = 225, s = 4
  localparam int          HOUR_SHIFT = 21;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;      // d = 15, s = 2
  localparam int          MIN_SHIFT  = 14;

  // 1970 mod 4, mod 100, mod 400
  localparam logic [1:0] EPOCH_MOD4   = 2'd2;
  localparam logic [6:0] EPOCH_MOD100 = 7'd70;
  localparam logic [8:0] EPOCH_MOD400 = 9'd370;
  localparam logic [6:0] LAST_MOD100  = 7'd99;
  localparam logic [8:0] LAST_MOD400  = 9'd399;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } div_sel_e;

  typedef struct packed {
    logic     load_count;
    logic     div_step;
    div_sel_e div_sel;
    logic     walk_init;
    logic     year_step;
    logic     month_step;
    logic     month_done;
    logic     load_hour;
    logic     load_min;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic day_match;
    logic year_fits;
    logic month_fits;
    logic out_busy;
  } dp_status_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== src/esc_ifs.sv =====
// Valid/ready channel interfaces: seconds count in, calendar date and time out.
// Uses no package.
interface esc_count_if #(
  parameter int CountWidth = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [CountWidth-1:0] seconds_count;

  modport source (output valid, output seconds_count, input ready);
  modport sink   (input valid, input seconds_count, output ready);
endinterface

interface esc_date_if ();
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, output ready);
endinterface

// ===== src/esc_datapath.sv =====
// Datapath: constant divisions by reciprocal multiply, cached date with year/month walk,
// output register. Depends on esc_pkg.
module esc_datapath #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  esc_pkg::ctrl_cmd_t      cmd_i,
  output esc_pkg::dp_status_t     status_o,
  input  logic [COUNT_WIDTH-1:0]  seconds_count_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [11:0]             year_o,
  output logic [3:0]              month_o,
  output logic [4:0]              day_of_month_o,
  output logic [4:0]              hour_o,
  output logic [5:0]              minute_o,
  output logic [5:0]              second_o
);

  localparam int DW = esc_pkg::DAY_WIDTH;
  localparam int TW = esc_pkg::TOD_WIDTH;
  localparam int MW = esc_pkg::MINSEC_WIDTH;

  // divisions, one multiply per step
  logic [31:0]    count_q, count_d;
  logic [DW-1:0]  day_q, day_d;
  logic [TW-1:0]  tod_q, tod_d;
  logic [MW-1:0]  minsec_q, minsec_d;
  logic [4:0]     hour_q, hour_d;
  logic [5:0]     min_q, min_d;
  logic [50:0]    day_prod;
  logic [26:0]    hour_prod;
  logic [20:0]    min_prod;
  logic [31:0]    day_secs;
  logic [16:0]    hour_secs;
  logic [11:0]    min_secs;
  logic [5:0]     sec_val;

  // walk and cache
  logic [DW-1:0]  days_q, days_d;
  logic [DW-1:0]  cache_day_q, cache_day_d;
  logic [11:0]    cache_year_q, cache_year_d;
  logic [3:0]     cache_month_q, cache_month_d;
  logic [4:0]     cache_dom_q, cache_dom_d;
  logic [1:0]     mod4_q, mod4_d;
  logic [6:0]     mod100_q, mod100_d;
  logic [8:0]     mod400_q, mod400_d;
  logic           leap;
  logic [8:0]     year_len;
  logic [4:0]     mon_len;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [11:0] out_year_q, out_year_d;
  logic [3:0]  out_month_q, out_month_d;
  logic [4:0]  out_dom_q, out_dom_d;
  logic [4:0]  out_hour_q, out_hour_d;
  logic [5:0]  out_min_q, out_min_d;
  logic [5:0]  out_sec_q, out_sec_d;

  // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15
  assign day_prod  = 51'(count_q[31:7]) * 51'(esc_pkg::DAY_RECIP);
  assign hour_prod = 27'(tod_q[TW-1:4]) * 27'(esc_pkg::HOUR_RECIP);
  assign min_prod  = 21'(minsec_q[MW-1:2]) * 21'(esc_pkg::MIN_RECIP);
  assign day_secs  = 32'(day_q) * 32'(esc_pkg::SECS_PER_DAY);
  assign hour_secs = 17'(hour_q) * 17'(esc_pkg::SECS_PER_HOUR);
  assign min_secs  = 12'(min_q) * 12'(esc_pkg::SECS_PER_MIN);
  assign sec_val   = 6'(minsec_q - min_secs);

  assign leap     = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
  assign year_len = leap ? esc_pkg::DAYS_LEAP : esc_pkg::DAYS_COMMON;
  assign mon_len  = esc_pkg::month_len(cache_month_q, leap);

  always_comb begin
    count_d       = count_q;
    day_d         = day_q;
    tod_d         = tod_q;
    minsec_d      = minsec_q;
    hour_d        = hour_q;
    min_d         = min_q;
    days_d        = days_q;
    cache_day_d   = cache_day_q;
    cache_year_d  = cache_year_q;
    cache_month_d = cache_month_q;
    cache_dom_d   = cache_dom_q;
    mod4_d        = mod4_q;
    mod100_d      = mod100_q;
    mod400_d      = mod400_q;

    if (cmd_i.load_count) begin
      count_d = 32'(seconds_count_i);
    end
    if (cmd_i.div_step) begin
      case (cmd_i.div_sel)
        esc_pkg::DIV_DAY:  day_d  = day_prod[esc_pkg::DAY_SHIFT +: DW];
        esc_pkg::DIV_HOUR: hour_d = hour_prod[esc_pkg::HOUR_SHIFT +: 5];
        esc_pkg::DIV_MIN:  min_d  = min_prod[esc_pkg::MIN_SHIFT +: 6];
        default: ;
      endcase
    end
    if (cmd_i.load_hour) begin
      tod_d = TW'(count_q - day_secs);
    end
    if (cmd_i.load_min) begin
      minsec_d = MW'(tod_q - hour_secs);
    end
    if (cmd_i.walk_init) begin
      days_d        = day_q;
      cache_day_d   = day_q;
      cache_year_d  = esc_pkg::EPOCH_YEAR;
      cache_month_d = esc_pkg::MONTH_JAN;
      mod4_d        = esc_pkg::EPOCH_MOD4;
      mod100_d      = esc_pkg::EPOCH_MOD100;
      mod400_d      = esc_pkg::EPOCH_MOD400;
    end
    if (cmd_i.year_step) begin
      days_d       = days_q - DW'(year_len);
      cache_year_d = cache_year_q + 12'd1;
      mod4_d       = mod4_q + 2'd1;
      mod100_d     = (mod100_q == esc_pkg::LAST_MOD100) ? 7'd0 : mod100_q + 7'd1;
      mod400_d     = (mod400_q == esc_pkg::LAST_MOD400) ? 9'd0 : mod400_q + 9'd1;
    end
    if (cmd_i.month_step) begin
      days_d        = days_q - DW'(mon_len);
      cache_month_d = cache_month_q + 4'd1;
    end
    if (cmd_i.month_done) begin
      cache_dom_d = days_q[4:0] + 5'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_year_d  = out_year_q;
    out_month_d = out_month_q;
    out_dom_d   = out_dom_q;
    out_hour_d  = out_hour_q;
    out_min_d   = out_min_q;
    out_sec_d   = out_sec_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      out_year_d  = cache_year_q;
      out_month_d = cache_month_q;
      out_dom_d   = cache_dom_q;
      out_hour_d  = hour_q;
      out_min_d   = min_q;
      out_sec_d   = sec_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      cache_day_q   <= '0;
      cache_year_q  <= esc_pkg::EPOCH_YEAR;
      cache_month_q <= esc_pkg::MONTH_JAN;
      cache_dom_q   <= 5'd1;
    end else begin
      out_valid_q   <= out_valid_d;
      cache_day_q   <= cache_day_d;
      cache_year_q  <= cache_year_d;
      cache_month_q <= cache_month_d;
      cache_dom_q   <= cache_dom_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q     <= count_d;
    day_q       <= day_d;
    tod_q       <= tod_d;
    minsec_q    <= minsec_d;
    hour_q      <= hour_d;
    min_q       <= min_d;
    days_q      <= days_d;
    mod4_q      <= mod4_d;
    mod100_q    <= mod100_d;
    mod400_q    <= mod400_d;
    out_year_q  <= out_year_d;
    out_month_q <= out_month_d;
    out_dom_q   <= out_dom_d;
    out_hour_q  <= out_hour_d;
    out_min_q   <= out_min_d;
    out_sec_q   <= out_sec_d;
  end

  always_comb begin
    status_o.day_match  = (day_q == cache_day_q);
    status_o.year_fits  = (days_q < DW'(year_len));
    status_o.month_fits = (days_q < DW'(mon_len)) || (cache_month_q == esc_pkg::MONTH_DEC);
    status_o.out_busy   = out_valid_q && !out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign year_o         = out_year_q;
  assign month_o        = out_month_q;
  assign day_of_month_o = out_dom_q;
  assign hour_o         = out_hour_q;
  assign minute_o       = out_min_q;
  assign second_o       = out_sec_q;

endmodule

// ===== src/esc_ctrl.sv =====
// Controller: sequences the divisions, the cache check, the year and month walk and output.
// Depends on esc_pkg.
module esc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output esc_pkg::ctrl_cmd_t  cmd_o,
  input  esc_pkg::dp_status_t status_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_DAY,
    S_CHECK,
    S_WALK_YEAR,
    S_WALK_MONTH,
    S_LOAD_HOUR,
    S_DIV_HOUR,
    S_LOAD_MIN,
    S_DIV_MIN,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = esc_pkg::DIV_DAY;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_count = 1'b1;
          state_d = S_DIV_DAY;
        end
      end
      S_DIV_DAY: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel  = esc_pkg::DIV_DAY;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // same day as last time: cached date is still good
        if (status_i.day_match) begin
          state_d = S_LOAD_HOUR;
        end else begin
          cmd_o.walk_init = 1'b1;
          state_d = S_WALK_YEAR;
        end
      end
      S_WALK_YEAR: begin
        if (status_i.year_fits) begin
          state_d = S_WALK_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      S_WALK_MONTH: begin
        if (status_i.month_fits) begin
          cmd_o.month_done = 1'b1;
          state_d = S_LOAD_HOUR;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      S_LOAD_HOUR: begin
        cmd_o.load_hour = 1'b1;
        state_d = S_DIV_HOUR;
      end
      S_DIV_HOUR: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel  = esc_pkg::DIV_HOUR;
        state_d = S_LOAD_MIN;
      end
      S_LOAD_MIN: begin
        cmd_o.load_min = 1'b1;
        state_d = S_DIV_MIN;
      end
      S_DIV_MIN: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel  = esc_pkg::DIV_MIN;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== src/epoch_seconds_to_calendar.sv =====
// Top level: seconds since 1970-01-01 to Gregorian date and time of day.
// Depends on esc_pkg, esc_ifs (channel interfaces), esc_ctrl and esc_datapath.
//
//   channel  dir  payload                                            handshake
//   in_i     in   seconds_count[COUNT_WIDTH-1:0]                     valid/ready
//   out_o    out  year, month, day_of_month, hour, minute, second    valid/ready
//
// One transaction at a time. After the accept the block divides out the day, checks it
// against the cached day and, on a new day, walks one year per step from 1970 and then
// one month per step; then it divides out the hour and the minute. The year walk sets the
// worst case; each division by a constant is one reciprocal multiply in its own state.
// Reset clears the cache to day 0 (1970-01-01) and empties the output register.
// in_i is accepted while a finished result still waits on out_o; the block holds
// its last step until the output register is free.
module epoch_seconds_to_calendar #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  esc_count_if.sink    in_i,
  esc_date_if.source   out_o
);

  esc_pkg::ctrl_cmd_t  cmd;
  esc_pkg::dp_status_t status;

  esc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  esc_datapath #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .seconds_count_i(in_i.seconds_count),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .year_o         (out_o.year),
    .month_o        (out_o.month),
    .day_of_month_o (out_o.day_of_month),
    .hour_o         (out_o.hour),
    .minute_o       (out_o.minute),
    .second_o       (out_o.second)
  );

endmodule

// ===== src/esc_checker.sv =====
// Port-level assertions for epoch_seconds_to_calendar, attached by bind.
// Depends on esc_pkg and epoch_seconds_to_calendar_defines.svh.
`include "epoch_seconds_to_calendar_defines.svh"

module esc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [11:0] year_i,
  input logic [3:0]  month_i,
  input logic [4:0]  day_of_month_i,
  input logic [4:0]  hour_i,
  input logic [5:0]  minute_i,
  input logic [5:0]  second_i
);

  // a stalled result stays put
  `ESC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(year_i) && $stable(month_i) && $stable(day_of_month_i) && $stable(hour_i) && $stable(minute_i) && $stable(second_i))

  // one transaction in flight: input closes right after an accept
  `ESC_ASSERT_NEXT(a_in_busy, in_valid_i && in_ready_i, !in_ready_i)

  // every shown result is a legal date and time; the day of month is checked only from below
  `ESC_ASSERT_NOW(a_out_range, out_valid_i, (year_i >= esc_pkg::EPOCH_YEAR) && (month_i >= 4'd1) && (month_i <= 4'd12) && (day_of_month_i >= 5'd1) && (hour_i <= 5'd23) && (minute_i <= 6'd59) && (second_i <= 6'd59))

  // a new result is loaded only while no input is open
  `ESC_ASSERT_NOW(a_out_rise, !$past(out_valid_i) && out_valid_i, !in_ready_i || $past(!in_ready_i))

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .year_i        (out_o.year),
  .month_i       (out_o.month),
  .day_of_month_i(out_o.day_of_month),
  .hour_i        (out_o.hour),
  .minute_i      (out_o.minute),
  .second_i      (out_o.second)
);
